// ===== sv/psmt_pkg.sv =====
// psmt_pkg: widths, reset values, header bit positions, register indexes and
// the coordinate clamp for the ps/2 mouse packet tracker
// depends on nothing
`timescale 1ns / 1ps

package psmt_pkg;

    // cursor coordinate width, 9 to 16
    localparam int COORD_BITS = 12;
    // bound register width
    localparam int BOUND_BITS = 13;
    // cursor plus a 9-bit signed delta, with sign
    localparam int SUM_BITS   = COORD_BITS + 2;
    // wide enough for a bound and for 2^COORD_BITS
    localparam int LIM_BITS   = (BOUND_BITS > COORD_BITS + 1) ? BOUND_BITS : COORD_BITS + 1;

    // register indexes on the configuration port
    localparam logic CFG_IDX_BITS = 1'b1;
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // reset values
    localparam logic [BOUND_BITS-1:0] WIDTH_RESET    = BOUND_BITS'(320);
    localparam logic [BOUND_BITS-1:0] HEIGHT_RESET   = BOUND_BITS'(200);
    localparam logic [COORD_BITS-1:0] CURSOR_X_RESET = COORD_BITS'(160);
    localparam logic [COORD_BITS-1:0] CURSOR_Y_RESET = COORD_BITS'(100);

    // header byte layout
    localparam int HDR_BTN_LSB   = 0;
    localparam int HDR_BTN_MSB   = 2;
    localparam int HDR_ALWAYS1   = 3;
    localparam int HDR_X_SIGN    = 4;
    localparam int HDR_Y_SIGN    = 5;

    // packet byte positions
    localparam logic [1:0] BYTE_HEADER = 2'd0;
    localparam logic [1:0] BYTE_X      = 2'd1;
    localparam logic [1:0] BYTE_Y      = 2'd2;

    // clamp v to [0, bound - 1]; a zero bound acts as one, a bound beyond the
    // coordinate range acts as 2^COORD_BITS
    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_BITS-1:0]   v,
        input logic        [BOUND_BITS-1:0] bound
    );
        logic        [LIM_BITS-1:0]   eff;
        logic        [LIM_BITS-1:0]   top_w;
        logic        [COORD_BITS-1:0] top;
        logic signed [SUM_BITS-1:0]   top_s;
        logic        [COORD_BITS-1:0] res;
        eff = LIM_BITS'(bound);
        if (eff == '0) begin
            eff = LIM_BITS'(1);
        end
        if (eff > (LIM_BITS'(1) << COORD_BITS)) begin
            eff = LIM_BITS'(1) << COORD_BITS;
        end
        top_w = eff - LIM_BITS'(1);
        top   = top_w[COORD_BITS-1:0];
        top_s = $signed({2'b00, top});
        if (v < 0) begin
            res = '0;
        end else if (v > top_s) begin
            res = top;
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/ps2_mouse_packet_tracker.sv =====
// ps2_mouse_packet_tracker: top level, three-byte ps/2 mouse packet decoder
// and clamped cursor tracker
// depends on psmt_pkg
`timescale 1ns / 1ps

// Takes one controller byte per beat with a flag saying whether it came from
// the mouse. Non-mouse beats are swallowed. Mouse bytes are collected three at
// a time; on the third, if the header has bit 3 set, the 9-bit signed deltas
// move the cursor (x added, y subtracted for screen orientation), each axis is
// clamped to [0, bound - 1] and one result beat carries position and buttons.
// A packet whose header has bit 3 clear is dropped whole with no realignment
// and no result. Writing a bound does not move the cursor; the new bound is
// used from the next valid packet. A zero bound acts as one, and a bound
// above 2^COORD_BITS saturates the cursor at 2^COORD_BITS - 1.
// Throughput is one byte per clock while the sink takes results: an input register
// feeds a single stage of add-and-clamp logic that writes the result register,
// and the cursor update finishes in that same cycle, so no packet waits on the
// one before. The third byte passes through the input register to the result register.
// The input side stalls only when its register is full and the result
// register holds a beat that the sink has not yet taken. Configuration writes
// are taken every cycle (cfg_ready is tied high) and must be made while idle.

module ps2_mouse_packet_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [psmt_pkg::BOUND_BITS-1:0]   cfg_data,
    // byte input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_from_mouse,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [psmt_pkg::COORD_BITS-1:0]   m_pos_x,
    output logic [psmt_pkg::COORD_BITS-1:0]   m_pos_y,
    output logic [2:0]                        m_button_bits
);

    import psmt_pkg::*;

    // configuration
    logic [BOUND_BITS-1:0] width_reg;
    logic [BOUND_BITS-1:0] height_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_mouse_reg;

    // packet assembly state
    logic [1:0] byte_count_reg;
    logic [1:0] byte_count_next;
    logic [7:0] header_reg;
    logic [7:0] x_byte_reg;

    // cursor state
    logic [COORD_BITS-1:0] cursor_x_reg;
    logic [COORD_BITS-1:0] cursor_y_reg;
    logic [COORD_BITS-1:0] cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_next;

    // result register
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [2:0]            out_btn_reg;

    // datapath
    logic                       advance;
    logic                       mouse_beat;
    logic                       last_byte;
    logic                       emit;
    logic signed [SUM_BITS-1:0] dx;
    logic signed [SUM_BITS-1:0] dy;
    logic signed [SUM_BITS-1:0] sum_x;
    logic signed [SUM_BITS-1:0] sum_y;

    assign cfg_ready = 1'b1;

    // the stage moves on when the result slot is empty or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign mouse_beat = advance && in_mouse_reg;
    assign last_byte  = mouse_beat && (byte_count_reg == BYTE_Y);
    assign emit       = last_byte && header_reg[HDR_ALWAYS1];

    // 9-bit deltas from the header sign bits, sign extended
    assign dx = SUM_BITS'($signed({header_reg[HDR_X_SIGN], x_byte_reg}));
    assign dy = SUM_BITS'($signed({header_reg[HDR_Y_SIGN], in_data_reg}));

    // x moves right with positive delta, y is flipped for screen orientation
    assign sum_x = $signed({2'b00, cursor_x_reg}) + dx;
    assign sum_y = $signed({2'b00, cursor_y_reg}) - dy;

    assign cursor_x_next = clamp_coord(sum_x, width_reg);
    assign cursor_y_next = clamp_coord(sum_y, height_reg);

    always_comb begin
        byte_count_next = byte_count_reg;
        if (mouse_beat) begin
            case (byte_count_reg)
                BYTE_HEADER: byte_count_next = BYTE_X;
                BYTE_X:      byte_count_next = BYTE_Y;
                default:     byte_count_next = BYTE_HEADER;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg  <= s_data_byte;
            in_mouse_reg <= s_from_mouse;
        end
    end

    // packet assembly and cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= BYTE_HEADER;
            cursor_x_reg   <= CURSOR_X_RESET;
            cursor_y_reg   <= CURSOR_Y_RESET;
        end else begin
            byte_count_reg <= byte_count_next;
            if (emit) begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
        end
    end

    // header and x bytes are always written before use, so no reset
    always_ff @(posedge aclk) begin
        if (mouse_beat && (byte_count_reg == BYTE_HEADER)) begin
            header_reg <= in_data_reg;
        end
        if (mouse_beat && (byte_count_reg == BYTE_X)) begin
            x_byte_reg <= in_data_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_x_reg   <= cursor_x_next;
            out_y_reg   <= cursor_y_next;
            out_btn_reg <= header_reg[HDR_BTN_MSB:HDR_BTN_LSB];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pos_x       = out_x_reg;
    assign m_pos_y       = out_y_reg;
    assign m_button_bits = out_btn_reg;

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for ps2_mouse_packet_tracker, with its own cursor
// predictor, a queue-fed beat driver and a result monitor
// depends on psmt_pkg and ps2_mouse_packet_tracker
`timescale 1ns / 1ps

module tb;

    import psmt_pkg::*;

    // run length guard, several times the slowest legal run
    localparam int LIMIT_CYCLES  = 400000;
    // cycles allowed after the last report for a trailing packet to finish
    localparam int SETTLE_CYCLES = 6;
    // random mouse beats per phase
    localparam int PHASE_BEATS   = 100;
    localparam int NUM_PHASES    = 8;
    localparam int REPORT_LIMIT  = 10;

    // one controller byte as it goes into the block
    typedef struct packed {
        logic [7:0] data;
        logic       mouse;
    } ps2_beat_t;

    // one cursor report as it comes out
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [2:0]            buttons;
    } cursor_report_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index     = REG_SCREEN_WIDTH;
    logic [BOUND_BITS-1:0] cfg_data      = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte   = '0;
    logic                  s_from_mouse  = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [COORD_BITS-1:0] m_pos_x;
    logic [COORD_BITS-1:0] m_pos_y;
    logic [2:0]            m_button_bits;

    // stimulus and scoreboard
    ps2_beat_t      pending_beats[$];
    cursor_report_t expected_reports[$];
    idle_mode_t     idle_mode = IDLE_NONE;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int beats_taken    = 0;
    int reports_seen   = 0;
    int bound_writes   = 0;

    // predictor state, mirrors the block after reset
    logic [1:0]            pkt_count  = BYTE_HEADER;
    logic [7:0]            pkt_header = '0;
    logic [7:0]            pkt_xbyte  = '0;
    logic [COORD_BITS-1:0] cur_x      = CURSOR_X_RESET;
    logic [COORD_BITS-1:0] cur_y      = CURSOR_Y_RESET;
    logic [BOUND_BITS-1:0] bound_x    = WIDTH_RESET;
    logic [BOUND_BITS-1:0] bound_y    = HEIGHT_RESET;

    ps2_mouse_packet_tracker u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_from_mouse  (s_from_mouse),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_button_bits (m_button_bits)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop if the block hangs or loses a report
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("ps2_mouse_packet_tracker regression: fail");
            $finish;
        end
    end

    // clamp to [0, bound - 1]; zero bound pins at 0, oversize bound saturates
    function automatic logic [COORD_BITS-1:0] clamp_axis(input int v,
                                                          input logic [BOUND_BITS-1:0] bound);
        int hi;
        hi = (bound == '0) ? 0 : int'(bound) - 1;
        if (hi > (1 << COORD_BITS) - 1) hi = (1 << COORD_BITS) - 1;
        if (v < 0) v = 0;
        else if (v > hi) v = hi;
        return COORD_BITS'(v);
    endfunction

    // feed one accepted byte through the predicted packet assembler
    task automatic advance_cursor(input ps2_beat_t b);
        int dx;
        int dy;
        if (!b.mouse) return;   // controller bytes leave the packet untouched
        case (pkt_count)
            BYTE_HEADER: begin
                pkt_header = b.data;
                pkt_count  = BYTE_X;
            end
            BYTE_X: begin
                pkt_xbyte = b.data;
                pkt_count = BYTE_Y;
            end
            default: begin
                pkt_count = BYTE_HEADER;
                // header without the always-one bit: whole packet is thrown away
                if (pkt_header[HDR_ALWAYS1]) begin
                    dx = int'(pkt_xbyte) - (pkt_header[HDR_X_SIGN] ? 256 : 0);
                    dy = int'(b.data)    - (pkt_header[HDR_Y_SIGN] ? 256 : 0);
                    // ps/2 y points up, screen y points down
                    cur_x = clamp_axis(int'(cur_x) + dx, bound_x);
                    cur_y = clamp_axis(int'(cur_y) - dy, bound_y);
                    expected_reports.push_back('{cur_x, cur_y,
                                                 pkt_header[HDR_BTN_MSB:HDR_BTN_LSB]});
                end
            end
        endcase
    endtask

    function automatic bit sender_gap();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 82;
            IDLE_BOTH:   return $urandom_range(99) < 14;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(99) < 82;
            IDLE_BOTH:     return $urandom_range(99) < 14;
            default:       return 1'b0;
        endcase
    endfunction

    // driver: one beat held until accepted, then the next one from the queue
    always @(posedge aclk) begin : drive_beats
        ps2_beat_t nb;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_cursor('{s_data_byte, s_from_mouse});
                beats_taken++;
            end
            // valid is only raised or lowered when nothing is waiting
            if (!s_valid || s_ready) begin
                if (pending_beats.size() != 0 && !sender_gap()) begin
                    nb = pending_beats.pop_front();
                    s_valid      <= 1'b1;
                    s_data_byte  <= nb.data;
                    s_from_mouse <= nb.mouse;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !receiver_stall();
        end
    end

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", what);
    endtask

    // monitor: every report against the oldest prediction, field by field
    always @(posedge aclk) begin : check_reports
        cursor_report_t want;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                note_mismatch($sformatf("unexpected report x=%0d y=%0d buttons=%0h",
                                        m_pos_x, m_pos_y, m_button_bits));
            end else begin
                want = expected_reports.pop_front();
                if (m_pos_x !== want.x)
                    note_mismatch($sformatf("report %0d pos_x expected %0d got %0d",
                                            reports_seen, want.x, m_pos_x));
                if (m_pos_y !== want.y)
                    note_mismatch($sformatf("report %0d pos_y expected %0d got %0d",
                                            reports_seen, want.y, m_pos_y));
                if (m_button_bits !== want.buttons)
                    note_mismatch($sformatf("report %0d buttons expected %0h got %0h",
                                            reports_seen, want.buttons, m_button_bits));
            end
        end
    end

    task automatic push_beat(input logic [7:0] data, input logic mouse);
        pending_beats.push_back('{data, mouse});
    endtask

    task automatic push_packet(input logic [7:0] hdr, input logic [7:0] xb,
                               input logic [7:0] yb);
        push_beat(hdr, 1'b1);
        push_beat(xb, 1'b1);
        push_beat(yb, 1'b1);
    endtask

    // wait until the block holds nothing, sampled at the falling edge so the
    // driver and monitor have settled
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_reports.size() != 0)
            @(negedge aclk);
        // an invalid trailing packet gives no report but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bound(input logic idx, input logic [BOUND_BITS-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SCREEN_WIDTH) bound_x = value;
        else                          bound_y = value;
        bound_writes++;
    endtask

    // delta byte biased towards full-scale moves so the cursor hits the edges
    function automatic logic [7:0] pick_delta();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly well-formed packets, some with controller bytes woven in, plus
    // broken headers, stray single bytes that shift alignment and pure noise
    task automatic gen_traffic(input int mouse_beats);
        int          sent;
        int          pick;
        int          k;
        logic [7:0]  pkt[3];
        sent = 0;
        while (sent < mouse_beats) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                pkt[0] = 8'($urandom_range(255)) | 8'(1 << HDR_ALWAYS1);
                pkt[1] = pick_delta();
                pkt[2] = pick_delta();
                for (k = 0; k < 3; k++) begin
                    push_beat(pkt[k], 1'b1);
                    if ($urandom_range(99) < 15) push_beat(8'($urandom_range(255)), 1'b0);
                end
                sent += 3;
            end else if (pick < 85) begin
                push_packet(8'($urandom_range(255)) & ~8'(1 << HDR_ALWAYS1),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
                sent += 3;
            end else if (pick < 95) begin
                push_beat(8'($urandom_range(255)), 1'b1);
                sent += 1;
            end else begin
                push_beat(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    initial begin : run_sequence
        int         ph;
        int         w_plan[NUM_PHASES];
        int         h_plan[NUM_PHASES];
        idle_mode_t mode_plan[NUM_PHASES];

        // bound plans, -1 for a random legal bound
        w_plan    = '{1, 4096, 0, 8191, 4097, -1, 320, 13};
        h_plan    = '{1, 4096, 0, 8191, 17,   -1, 200, 4000};
        mode_plan = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part on reset bounds (320 x 200, cursor at 160,100)
        push_beat(8'h08, 1'b0);             // lone controller byte before any packet
        push_packet(8'h08, 8'h00, 8'h00);   // zero move, no buttons
        push_packet(8'h0F, 8'hFF, 8'hFF);   // +255 both, x hits right edge, y hits top
        push_packet(8'h38, 8'h00, 8'h00);   // -256 both, y hits bottom edge
        push_beat(8'h09, 1'b1);             // packet interleaved with controller bytes
        push_beat(8'hFF, 1'b0);
        push_beat(8'h80, 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'h7F, 1'b1);
        push_packet(8'hF7, 8'h55, 8'hAA);   // header bit 3 clear: dropped whole
        push_packet(8'h1A, 8'h01, 8'h80);   // x sign set, y sign clear
        push_packet(8'h28, 8'h7F, 8'h01);   // y sign set, x sign clear
        wait_idle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_bound(REG_SCREEN_WIDTH,
                        (w_plan[ph] < 0) ? BOUND_BITS'($urandom_range(1, 4096))
                                         : BOUND_BITS'(w_plan[ph]));
            write_bound(REG_SCREEN_HEIGHT,
                        (h_plan[ph] < 0) ? BOUND_BITS'($urandom_range(1, 4096))
                                         : BOUND_BITS'(h_plan[ph]));
            idle_mode = mode_plan[ph];
            if (ph == 3) begin
                // sender holds off mid-phase until every report is back
                gen_traffic(PHASE_BEATS / 2);
                wait_idle();
                gen_traffic(PHASE_BEATS - PHASE_BEATS / 2);
            end else begin
                gen_traffic(PHASE_BEATS);
            end
            wait_idle();
        end

        idle_mode = IDLE_NONE;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("ran %0d beats through %0d bound writes, %0d cursor reports checked",
                 beats_taken, bound_writes, reports_seen);
        $display("bounds included zero, one, full range and oversize, under four idling mixes");
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("ps2_mouse_packet_tracker regression: pass");
        end else begin
            $display("%0d mismatches, %0d reports outstanding",
                     mismatch_count, expected_reports.size());
            $display("ps2_mouse_packet_tracker regression: fail");
        end
        $finish;
    end

endmodule
